[src/mts_pkg.sv]
package mts_pkg;

	localparam int DATA_W = 32;

	typedef logic signed [DATA_W-1:0] data_t;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_POP_EMPTY = 2'd1,
		ERR_PUSH_FULL = 2'd2
	} err_t;

endpackage

[src/min_tracking_stack_top.sv]
// Stack of signed 32-bit values that also tracks its minimum.
//
// Input channel (s_axis_*): one transfer is one operation. s_axis_tuser[0]
// selects push (0) or pop (1); s_axis_tdata carries the value to push and is
// ignored on a pop.
// Output channel (m_axis_*): exactly one transfer per operation, in order,
// reporting the minimum (0 when empty), the depth, an empty flag and an error
// code (0 ok, 1 pop on empty, 2 push on full). Failed operations leave the
// stack unchanged.
//
// A push or a failed operation shows its result the cycle after acceptance.
// A successful pop passes through the refill state, which holds off new operations:
// the entries below the cached tops are read from the value and minimum
// memories (registered reads) before the result is formed.
// Values and minima live in two single-port-write, registered-read memories
// of STACK_DEPTH entries; only the top of each stack is held in flops.
// Reset clears both counts, so the stack comes up empty; no clearing pass.
// The result sits in an output register; while the receiver stalls a held
// result blocks only the next operation, and s_axis_tready drops until the
// register can be reloaded.
module min_tracking_stack_top #(
	parameter int STACK_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] push_value
	input  logic [0:0]  s_axis_tuser,  // [0] opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata   // [31:0] min_value, [38:32] depth,
	                                   // [39] is_empty, [41:40] error_code
);
	import mts_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	typedef enum logic {
		ST_IDLE,
		ST_REFILL
	} state_t;

	state_t         state_q;
	logic [CW-1:0]  vcnt_q;
	logic [CW-1:0]  mcnt_q;
	data_t          vtop_q;
	data_t          mtop_q;
	logic           refill_v_q;
	logic           refill_m_q;
	logic           out_valid_q;
	data_t          out_min_q;
	logic [6:0]     out_depth_q;
	logic           out_empty_q;
	err_t           out_err_q;

	logic           accept;
	op_t            op;
	data_t          in_value;
	logic           is_full;
	logic           is_zero;
	logic           push_ok;
	logic           push_min;
	logic           pop_ok;
	logic           pop_min;
	logic [CW-1:0]  vcnt_dec;
	logic [CW-1:0]  vcnt_dec2;
	logic [CW-1:0]  vcnt_inc;
	logic [CW-1:0]  mcnt_dec;
	logic [CW-1:0]  mcnt_dec2;
	logic [CW-1:0]  mcnt_inc;
	data_t          v_rdata;
	data_t          m_rdata;
	data_t          imm_min;
	logic [CW-1:0]  imm_depth;
	err_t           imm_err;
	data_t          ref_min;

	assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign op            = op_t'(s_axis_tuser[0]);
	assign in_value      = data_t'(s_axis_tdata);

	assign is_full   = (vcnt_q == CW'(STACK_DEPTH));
	assign is_zero   = (vcnt_q == '0);
	assign vcnt_dec  = vcnt_q - CW'(1);
	assign vcnt_dec2 = vcnt_q - CW'(2);
	assign vcnt_inc  = vcnt_q + CW'(1);
	assign mcnt_dec  = mcnt_q - CW'(1);
	assign mcnt_dec2 = mcnt_q - CW'(2);
	assign mcnt_inc  = mcnt_q + CW'(1);

	assign push_ok  = accept && (op == OP_PUSH) && !is_full;
	assign push_min = push_ok && ((mcnt_q == '0) || (in_value <= mtop_q));
	assign pop_ok   = accept && (op == OP_POP) && !is_zero;
	assign pop_min  = pop_ok && (mcnt_q != '0) && (vtop_q == mtop_q);

	mts_ram #(
		.DEPTH (STACK_DEPTH),
		.AW    (AW)
	) u_value_ram (
		.clk   (clk),
		.we    (push_ok),
		.waddr (vcnt_q[AW-1:0]),
		.wdata (in_value),
		.raddr (vcnt_dec2[AW-1:0]),
		.rdata (v_rdata)
	);

	mts_ram #(
		.DEPTH (STACK_DEPTH),
		.AW    (AW)
	) u_min_ram (
		.clk   (clk),
		.we    (push_min),
		.waddr (mcnt_q[AW-1:0]),
		.wdata (in_value),
		.raddr (mcnt_dec2[AW-1:0]),
		.rdata (m_rdata)
	);

	// result of a push or a failed operation, known in the accept cycle
	always_comb begin
		imm_min   = '0;
		imm_depth = vcnt_q;
		imm_err   = ERR_NONE;
		if (push_min) begin
			imm_min = in_value;
		end else if (mcnt_q != '0) begin
			imm_min = mtop_q;
		end
		if (push_ok) begin
			imm_depth = vcnt_inc;
		end
		if (op == OP_PUSH && is_full) begin
			imm_err = ERR_PUSH_FULL;
		end else if (op == OP_POP && is_zero) begin
			imm_err = ERR_POP_EMPTY;
		end
	end

	// result of a pop, after the new minimum arrives from memory
	always_comb begin
		ref_min = '0;
		if (mcnt_q != '0) begin
			ref_min = refill_m_q ? m_rdata : mtop_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			vcnt_q      <= '0;
			mcnt_q      <= '0;
			vtop_q      <= '0;
			mtop_q      <= '0;
			refill_v_q  <= 1'b0;
			refill_m_q  <= 1'b0;
			out_valid_q <= 1'b0;
			out_min_q   <= '0;
			out_depth_q <= '0;
			out_empty_q <= 1'b1;
			out_err_q   <= ERR_NONE;
		end else begin
			// drop the taken result unless a new one replaces it this cycle
			if (out_valid_q && m_axis_tready && (!accept || pop_ok)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						refill_v_q <= pop_ok && (vcnt_dec != '0);
						refill_m_q <= pop_min && (mcnt_dec != '0);
						if (push_ok) begin
							vcnt_q <= vcnt_inc;
							vtop_q <= in_value;
						end
						if (push_min) begin
							mcnt_q <= mcnt_inc;
							mtop_q <= in_value;
						end
						if (pop_ok) begin
							vcnt_q  <= vcnt_dec;
							state_q <= ST_REFILL;
						end
						if (pop_min) begin
							mcnt_q <= mcnt_dec;
						end
						if (!pop_ok) begin
							out_valid_q <= 1'b1;
							out_min_q   <= imm_min;
							out_depth_q <= 7'(imm_depth);
							out_empty_q <= (imm_depth == '0);
							out_err_q   <= imm_err;
						end
					end
				end
				ST_REFILL: begin
					// load the new tops read below the popped entries
					if (refill_v_q) begin
						vtop_q <= v_rdata;
					end
					if (refill_m_q) begin
						mtop_q <= m_rdata;
					end
					out_valid_q <= 1'b1;
					out_min_q   <= ref_min;
					out_depth_q <= 7'(vcnt_q);
					out_empty_q <= (vcnt_q == '0);
					out_err_q   <= ERR_NONE;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_err_q, out_empty_q, out_depth_q, out_min_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vcnt_q <= CW'(STACK_DEPTH))
		else $error("value count exceeds stack depth");

	a_min_count_le: assert property (@(posedge clk) disable iff (!arst_n)
		mcnt_q <= vcnt_q)
		else $error("minimum count exceeds value count");

	a_refill_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_REFILL |-> !out_valid_q)
		else $error("output register busy during refill");

	a_pop_refills: assert property (@(posedge clk) disable iff (!arst_n)
		pop_ok |=> state_q == ST_REFILL)
		else $error("pop did not enter refill");

	a_empty_min_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_empty_q |-> out_min_q == '0 && out_depth_q == '0)
		else $error("empty result with nonzero minimum or depth");

endmodule

[src/mts_ram.sv]
module mts_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  mts_pkg::data_t  wdata,
	input  logic [AW-1:0]   raddr,
	output mts_pkg::data_t  rdata
);
	import mts_pkg::*;

	data_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[verif/tb_min_tracking_stack_top.sv]
module tb_min_tracking_stack_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mts_pkg::*;

	localparam int STACK_DEPTH  = 64;
	localparam int RANDOM_OPS   = 1050;
	localparam int CALM_OPS     = 150;
	localparam int HOLD_CYCLES  = 120;
	localparam int SETTLE       = 10;
	localparam int MAX_REPORTS  = 10;

	typedef struct {
		data_t      min_value;
		logic [6:0] depth;
		logic       is_empty;
		err_t       err;
	} stack_status_t;

	// Shadow copy of the stack and its minima; predicts the status word of each operation.
	class min_stack_shadow;
		data_t         values[STACK_DEPTH];
		data_t         minima[STACK_DEPTH];
		int unsigned   n_values;
		int unsigned   n_minima;
		stack_status_t pending_status[$];
		int            failures;
		int            results_seen;

		function new();
			n_values     = 0;
			n_minima     = 0;
			failures     = 0;
			results_seen = 0;
		endfunction

		function int pending();
			return pending_status.size();
		endfunction

		function void note_op(op_t op, data_t value);
			stack_status_t s;
			s.err = ERR_NONE;
			if (op == OP_PUSH) begin
				if (n_values == STACK_DEPTH) begin
					s.err = ERR_PUSH_FULL;
				end else begin
					values[n_values] = value;
					n_values++;
					// equal values go onto the minima too, so duplicates pop cleanly
					if (n_minima == 0 || value <= minima[n_minima-1]) begin
						minima[n_minima] = value;
						n_minima++;
					end
				end
			end else if (n_values == 0) begin
				s.err = ERR_POP_EMPTY;
			end else begin
				n_values--;
				if (n_minima != 0 && values[n_values] == minima[n_minima-1])
					n_minima--;
			end
			s.min_value = (n_minima != 0 && n_values != 0) ? minima[n_minima-1] : '0;
			s.depth     = 7'(n_values);
			s.is_empty  = (n_values == 0);
			pending_status.push_back(s);
		endfunction

		function void check_status(logic [47:0] word);
			stack_status_t want;
			stack_status_t got;
			got.min_value = word[31:0];
			got.depth     = word[38:32];
			got.is_empty  = word[39];
			got.err       = err_t'(word[41:40]);
			results_seen++;
			if (pending_status.size() == 0) begin
				failures++;
				if (failures <= MAX_REPORTS)
					$display("result %0d: no operation pending, got %h", results_seen, word);
				return;
			end
			want = pending_status.pop_front();
			if (got.min_value !== want.min_value || got.depth !== want.depth ||
			    got.is_empty !== want.is_empty || got.err !== want.err) begin
				failures++;
				if (failures <= MAX_REPORTS)
					$display("result %0d: expected min %0d depth %0d empty %0b err %0d, %s",
						results_seen, want.min_value, want.depth, want.is_empty, want.err,
						$sformatf("got min %0d depth %0d empty %0b err %0d",
							got.min_value, got.depth, got.is_empty, got.err));
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;  // [31:0] push_value
	logic [0:0]  s_axis_tuser = '0;  // [0] opcode
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;       // [31:0] min_value, [38:32] depth,
	                                 // [39] is_empty, [41:40] error_code

	min_stack_shadow shadow = new();
	bit              calm = 1'b0;
	bit              hold_output = 1'b0;

	min_tracking_stack_top #(
		.STACK_DEPTH(STACK_DEPTH)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// Receiver: random stalls, one long hold-off on request, always ready when calm.
	initial begin
		forever begin
			if (hold_output) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_output = 1'b0;
			end else if (calm) begin
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end else if ($urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			shadow.check_status(m_axis_tdata);
	end

	function automatic data_t pick_value();
		case ($urandom_range(0, 4))
			0, 1: return data_t'($urandom);
			2, 3: return data_t'($urandom_range(0, 8) - 4);
			default: begin
				case ($urandom_range(0, 3))
					0: return data_t'(32'h8000_0000);
					1: return data_t'(32'h7FFF_FFFF);
					2: return data_t'(32'h8000_0001);
					default: return data_t'(32'h7FFF_FFFE);
				endcase
			end
		endcase
	endfunction

	// Offer one operation and hold it until the transfer; returns at the accepting edge.
	task automatic apply_op(op_t op, data_t value);
		if (!calm && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= value;
		do @(posedge clk); while (!s_axis_tready);
		shadow.note_op(op, value);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (shadow.pending() != 0) @(posedge clk);
	endtask

	initial begin
		int sent;
		int phase;
		int phase_len;
		int push_pct;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pop on empty, extremes, duplicate minima, drain back past empty
		apply_op(OP_POP, data_t'($urandom));
		apply_op(OP_PUSH, data_t'(32'h7FFF_FFFF));
		apply_op(OP_PUSH, data_t'(32'h8000_0000));
		apply_op(OP_PUSH, data_t'(32'h8000_0000));
		apply_op(OP_PUSH, data_t'(-1));
		apply_op(OP_PUSH, data_t'(5));
		apply_op(OP_POP, data_t'($urandom));
		apply_op(OP_POP, data_t'($urandom));
		apply_op(OP_POP, data_t'($urandom));
		apply_op(OP_POP, data_t'($urandom));
		apply_op(OP_POP, data_t'($urandom));
		apply_op(OP_POP, data_t'($urandom));
		apply_op(OP_PUSH, data_t'(0));
		apply_op(OP_PUSH, data_t'(0));
		apply_op(OP_PUSH, data_t'(1));
		apply_op(OP_PUSH, data_t'(-1));
		apply_op(OP_POP, data_t'($urandom));
		apply_op(OP_POP, data_t'($urandom));
		apply_op(OP_POP, data_t'($urandom));
		apply_op(OP_POP, data_t'($urandom));
		apply_op(OP_POP, data_t'($urandom));

		sent  = 0;
		phase = 0;
		while (sent < RANDOM_OPS) begin
			phase_len = $urandom_range(20, 90);
			case ($urandom_range(0, 2))
				0: push_pct = 88;
				1: push_pct = 12;
				default: push_pct = 50;
			endcase
			// pushes only, past full, while the receiver holds off
			if (phase == 3) begin
				hold_output = 1'b1;
				push_pct    = 100;
				phase_len   = 80;
			end
			if (phase == 7)
				drain_results();
			for (int i = 0; i < phase_len; i++) begin
				calm = (sent >= RANDOM_OPS - CALM_OPS);
				if ($urandom_range(0, 99) < push_pct)
					apply_op(OP_PUSH, pick_value());
				else
					apply_op(OP_POP, data_t'($urandom));
				sent++;
			end
			phase++;
		end

		s_axis_tvalid <= 1'b0;
		while (shadow.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (shadow.failures + shadow.pending() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

[files.f]
src/mts_pkg.sv
src/mts_ram.sv
src/min_tracking_stack_top.sv
verif/tb_min_tracking_stack_top.sv
